FILE: hdl/jvsio_pkg.sv
package jvsio_pkg;

   // coin slots kept by the board; the host-side switch inputs cover two of them
   localparam int COIN_SLOTS    = 2;
   localparam int SWITCH_INPUTS = 2;
   localparam int REPLY_BYTES   = 2 * COIN_SLOTS;
   localparam int BYTE_IDX_W    = $clog2(REPLY_BYTES);
   localparam int SLOT_CNT_W    = $clog2(COIN_SLOTS + 1);

   localparam int ID_LEN = 59;
   localparam int LEN_W  = $clog2(ID_LEN + 1);
   localparam int IDX_W  = $clog2(ID_LEN);

   // command codes
   localparam logic [7:0] CMD_IDENTIFY = 8'h10;
   localparam logic [7:0] CMD_REVISION = 8'h11;
   localparam logic [7:0] CMD_JVS_VER  = 8'h12;
   localparam logic [7:0] CMD_COMM_VER = 8'h13;
   localparam logic [7:0] CMD_MAIN_ID  = 8'h15;
   localparam logic [7:0] CMD_COIN_RD  = 8'h21;
   localparam logic [7:0] CMD_COIN_ADD = 8'h35;
   localparam logic [7:0] CMD_VENDOR   = 8'h70;
   localparam logic [7:0] CMD_RESET    = 8'hF0;
   localparam logic [7:0] CMD_SET_ADDR = 8'hF1;

   localparam logic [7:0] VENDOR_SUB   = 8'h18;
   localparam logic [7:0] REV_BYTE     = 8'h11;
   localparam logic [7:0] JVS_VER_BYTE = 8'h20;
   localparam logic [7:0] COMM_VER_BYTE = 8'h10;
   localparam logic [7:0] VENDOR_BYTE  = 8'hFF;

   // report codes
   localparam logic [1:0] RPT_NORMAL   = 2'd0;
   localparam logic [1:0] RPT_SIZE_ERR = 2'd1;
   localparam logic [1:0] RPT_DATA_ERR = 2'd2;

   // configuration register indexes
   localparam logic CSR_DIP_ZERO = 1'b0;
   localparam logic CSR_DIP_ONE  = 1'b1;

   localparam logic [7:0] ID_ROM [ID_LEN] = '{
      8'h6E, 8'h61, 8'h6D, 8'h63, 8'h6F, 8'h20, 8'h6C, 8'h74, 8'h64, 8'h2E,
      8'h3B, 8'h46, 8'h43, 8'h41, 8'h2D, 8'h31,
      8'h3B, 8'h56, 8'h65, 8'h72, 8'h31, 8'h2E, 8'h30, 8'h31,
      8'h3B, 8'h4A, 8'h50, 8'h4E, 8'h2C,
      8'h4D, 8'h75, 8'h6C, 8'h74, 8'h69, 8'h70, 8'h75, 8'h72, 8'h70, 8'h6F, 8'h73, 8'h65,
      8'h20, 8'h2B, 8'h20,
      8'h52, 8'h6F, 8'h74, 8'h61, 8'h72, 8'h79,
      8'h20, 8'h45, 8'h6E, 8'h63, 8'h6F, 8'h64, 8'h65, 8'h72,
      8'h00
   };

   typedef logic [COIN_SLOTS-1:0][15:0] coin_bank_type;

   typedef struct packed {
      logic [1:0]                       code;
      logic                             valid;
      logic                             from_rom;
      logic [LEN_W-1:0]                 len;
      logic [REPLY_BYTES-1:0][7:0]      bytes;
      logic                             setup;
   } reply_desc_type;

endpackage

FILE: hdl/jvs_io_command_responder.sv
// the first reply transaction of a command is offered in the cycle after the command
// is taken; the reply register holds the command until its last reply byte is taken
// throughput: one command per cycle when each reply is a single item and the reply
// port is ready; otherwise a new command waits for the last byte of the reply
// reset: synchronous, active high; clears coin counts, switch history, setup bit,
// DIP registers and the reply register's valid bit and byte pointer
module jvs_io_command_responder (
   input  logic        clock,
   input  logic        reset,

   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tuser,   // req_type
   // arg_count[2:0], arg_first[10:3], arg_second[18:11], arg_third[26:19],
   // arg_fourth[34:27], arg_fifth[42:35], payload_has_null[43],
   // coin_switch_a[44], coin_switch_b[45], zero fill[47:46]
   input  logic [47:0] req_tdata,

   // reply channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // last_of_reply
   output logic        rsp_tuser,   // reply_valid
   // report_code[1:0], reply_byte[9:2], setup_bit[10], zero fill[15:11]
   output logic [15:0] rsp_tdata,

   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // command decode outputs
   jvsio_pkg::reply_desc_type           desc;
   logic                                setup_in;
   jvsio_pkg::coin_bank_type            coin_count_in;
   logic [jvsio_pkg::COIN_SLOTS-1:0]    coin_seen_in;

   // board state
   logic                                setup_ff;
   jvsio_pkg::coin_bank_type            coin_count_ff;
   logic [jvsio_pkg::COIN_SLOTS-1:0]    coin_seen_ff;
   // DIP switch bytes written through the configuration port; bit 0 of the second byte is not kept
   logic [7:0]                          dip_zero_ff;
   logic [7:1]                          dip_one_ff;

   // reply register: the command in flight and the byte pointer into it
   jvsio_pkg::reply_desc_type           job_ff;
   logic                                job_valid_ff;
   logic [jvsio_pkg::IDX_W-1:0]         idx_ff;

   logic                                req_take;
   logic                                rsp_take;
   logic                                job_last;
   logic [7:0]                          reply_byte;

   jvsio_decode u_decode (
      .cmd              (req_tuser),
      .cnt              (req_tdata[2:0]),
      .arg_first        (req_tdata[10:3]),
      .arg_second       (req_tdata[18:11]),
      .arg_third        (req_tdata[26:19]),
      .payload_has_null (req_tdata[43]),
      .coin_sw          (req_tdata[45:44]),
      .setup_ff         (setup_ff),
      .coin_count_ff    (coin_count_ff),
      .coin_seen_ff     (coin_seen_ff),
      .desc             (desc),
      .setup_in         (setup_in),
      .coin_count_in    (coin_count_in),
      .coin_seen_in     (coin_seen_in)
   );

   // last byte of the command in the reply register
   assign job_last   = (jvsio_pkg::LEN_W'(idx_ff) == job_ff.len - jvsio_pkg::LEN_W'(1));
   assign rsp_take   = job_valid_ff && rsp_tready;

   // a new command enters when the register is empty or its last byte leaves now
   assign req_tready = !job_valid_ff || (rsp_tready && job_last);
   assign req_take   = req_tvalid && req_tready;

   // identify streams from the id rom, everything else from the small byte buffer
   assign reply_byte = job_ff.from_rom ? jvsio_pkg::ID_ROM[idx_ff] :
                       job_ff.bytes[idx_ff[jvsio_pkg::BYTE_IDX_W-1:0]];

   assign rsp_tvalid = job_valid_ff;
   assign rsp_tlast  = job_last;
   assign rsp_tuser  = job_ff.valid;
   assign rsp_tdata  = {5'd0, job_ff.setup, reply_byte, job_ff.code};

   // board state moves when a command is taken, so replies follow command order
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff      <= 1'b0;
         coin_count_ff <= '0;
         coin_seen_ff  <= '0;
      end else if (req_take) begin
         setup_ff      <= setup_in;
         coin_count_ff <= coin_count_in;
         coin_seen_ff  <= coin_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_zero_ff <= 8'd0;
         dip_one_ff  <= 7'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            jvsio_pkg::CSR_DIP_ZERO: dip_zero_ff <= csr_wdata;
            jvsio_pkg::CSR_DIP_ONE:  dip_one_ff  <= csr_wdata[7:1];
            default:                 dip_zero_ff <= dip_zero_ff;
         endcase
      end
   end

   // reply register control
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (req_take) begin
         job_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (rsp_take) begin
         if (job_last) begin
            job_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + jvsio_pkg::IDX_W'(1);
         end
      end
   end

   // reply payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         job_ff <= desc;
      end
   end

endmodule

FILE: hdl/jvsio_decode.sv
module jvsio_decode (
   input  logic [7:0]                          cmd,
   input  logic [2:0]                          cnt,
   input  logic [7:0]                          arg_first,
   input  logic [7:0]                          arg_second,
   input  logic [7:0]                          arg_third,
   input  logic                                payload_has_null,
   input  logic [jvsio_pkg::SWITCH_INPUTS-1:0] coin_sw,
   input  logic                                setup_ff,
   input  jvsio_pkg::coin_bank_type            coin_count_ff,
   input  logic [jvsio_pkg::COIN_SLOTS-1:0]    coin_seen_ff,
   output jvsio_pkg::reply_desc_type           desc,
   output logic                                setup_in,
   output jvsio_pkg::coin_bank_type            coin_count_in,
   output logic [jvsio_pkg::COIN_SLOTS-1:0]    coin_seen_in
);

   logic [jvsio_pkg::COIN_SLOTS+jvsio_pkg::SWITCH_INPUTS-1:0] sw_wide;
   logic [jvsio_pkg::COIN_SLOTS-1:0]                          level;
   logic [jvsio_pkg::SLOT_CNT_W-1:0]                          n_read;

   // slots past the switch inputs see a low level
   assign sw_wide = {{jvsio_pkg::COIN_SLOTS{1'b0}}, coin_sw};
   assign level   = sw_wide[jvsio_pkg::COIN_SLOTS-1:0];
   assign n_read  = (arg_first < jvsio_pkg::COIN_SLOTS) ?
                    jvsio_pkg::SLOT_CNT_W'(arg_first) :
                    jvsio_pkg::SLOT_CNT_W'(jvsio_pkg::COIN_SLOTS);

   always_comb begin
      desc          = '0;
      desc.code     = jvsio_pkg::RPT_NORMAL;
      desc.len      = jvsio_pkg::LEN_W'(1);
      setup_in      = setup_ff;
      coin_count_in = coin_count_ff;
      coin_seen_in  = coin_seen_ff;

      unique case (cmd)
         jvsio_pkg::CMD_IDENTIFY: begin
            desc.valid    = 1'b1;
            desc.from_rom = 1'b1;
            desc.len      = jvsio_pkg::LEN_W'(jvsio_pkg::ID_LEN);
         end
         jvsio_pkg::CMD_REVISION: begin
            desc.valid    = 1'b1;
            desc.bytes[0] = jvsio_pkg::REV_BYTE;
         end
         jvsio_pkg::CMD_JVS_VER: begin
            desc.valid    = 1'b1;
            desc.bytes[0] = jvsio_pkg::JVS_VER_BYTE;
         end
         jvsio_pkg::CMD_COMM_VER: begin
            desc.valid    = 1'b1;
            desc.bytes[0] = jvsio_pkg::COMM_VER_BYTE;
         end
         jvsio_pkg::CMD_MAIN_ID: begin
            desc.code = (cnt != 3'd0 && payload_has_null) ?
                        jvsio_pkg::RPT_NORMAL : jvsio_pkg::RPT_DATA_ERR;
         end
         jvsio_pkg::CMD_COIN_RD: begin
            if (cnt == 3'd0) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else begin
               for (int i = 0; i < jvsio_pkg::COIN_SLOTS; i++) begin
                  if (i < n_read) begin
                     if (level[i] && !coin_seen_ff[i]) begin
                        coin_count_in[i] = coin_count_ff[i] + 16'd1;
                     end
                     coin_seen_in[i]    = level[i];
                     desc.bytes[2*i]    = {2'b00, coin_count_in[i][13:8]};
                     desc.bytes[2*i+1]  = coin_count_in[i][7:0];
                  end
               end
               if (n_read != '0) begin
                  desc.valid = 1'b1;
                  desc.len   = jvsio_pkg::LEN_W'({n_read, 1'b0});
               end
            end
         end
         jvsio_pkg::CMD_COIN_ADD: begin
            if (cnt < 3'd3) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else begin
               // a slot number past the last slot is dropped
               for (int i = 0; i < jvsio_pkg::COIN_SLOTS; i++) begin
                  if (arg_first == 8'(i)) begin
                     coin_count_in[i] = coin_count_ff[i] + {arg_second, arg_third};
                  end
               end
            end
         end
         jvsio_pkg::CMD_VENDOR: begin
            if (cnt == 3'd0) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else if (arg_first != jvsio_pkg::VENDOR_SUB) begin
               desc.code = jvsio_pkg::RPT_DATA_ERR;
            end else if (cnt < 3'd5) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else begin
               desc.valid    = 1'b1;
               desc.bytes[0] = jvsio_pkg::VENDOR_BYTE;
            end
         end
         jvsio_pkg::CMD_RESET: begin
            if (cnt == 3'd0) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else begin
               setup_in = 1'b1;
            end
         end
         jvsio_pkg::CMD_SET_ADDR: begin
            if (cnt == 3'd0) begin
               desc.code = jvsio_pkg::RPT_SIZE_ERR;
            end else begin
               desc.valid    = 1'b1;
               desc.bytes[0] = {7'd0, arg_first == 8'd1};
               setup_in      = 1'b0;
            end
         end
         default: begin
            desc.code = jvsio_pkg::RPT_DATA_ERR;
         end
      endcase

      desc.setup = setup_in;
   end

endmodule

FILE: hdl/jvsio_checker.sv
module jvsio_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tlast,
   input logic        rsp_tuser,
   input logic [15:0] rsp_tdata
);

   // reply register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("reply offered right after reset");

   // a taken command always shows up as a reply transaction next cycle
   a_cmd_to_reply: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("command taken but no reply offered");

   // a stalled reply blocks new commands
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("command taken while reply stalled");

   // a reply without data is a single-transaction reply
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[9:2] == 8'd0)
      else $error("reply without data is not a lone last transaction");

   // stalled reply holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled reply changed");

endmodule

bind jvs_io_command_responder jvsio_checker u_jvsio_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
